@@ src/mide_pkg.sv @@
// mide_pkg: shared types and constants of the message-id list extractor
// no dependencies; used by the top level
`default_nettype none

package mide_pkg;

   localparam logic [7:0] CharLt        = 8'h3C;
   localparam logic [7:0] CharGt        = 8'h3E;
   localparam logic [7:0] CharLparen    = 8'h28;
   localparam logic [7:0] CharRparen    = 8'h29;
   localparam logic [7:0] CharBackslash = 8'h5C;
   localparam logic [7:0] CharSpace     = 8'h20;
   localparam logic [7:0] CharTab       = 8'h09;
   localparam logic [7:0] CharCr        = 8'h0D;

   localparam int         DepthWidth      = 8;
   localparam logic [DepthWidth-1:0] MaxCommentDepth = DepthWidth'(255);

   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   typedef enum logic [5:0] {
      PH_LEAD     = 6'b000001,
      PH_LEAD_CMT = 6'b000010,
      PH_TEXT     = 6'b000100,
      PH_POST     = 6'b001000,
      PH_POST_CMT = 6'b010000,
      PH_ID       = 6'b100000
   } phase_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] id_byte;
      logic       id_last;
      logic       header_done;
   } result_type;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == CharSpace) || ((b >= CharTab) && (b <= CharCr));
   endfunction

endpackage

`default_nettype wire

@@ src/mide_req_if.sv @@
// mide_req_if: input channel carrying one header byte per beat
// depends on nothing
`default_nettype none

interface mide_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_header;

   modport source (output valid, output in_byte, output end_of_header, input ready);
   modport sink   (input valid, input in_byte, input end_of_header, output ready);
endinterface

`default_nettype wire

@@ src/mide_rsp_if.sv @@
// mide_rsp_if: result channel carrying one message-id byte per beat
// depends on nothing
`default_nettype none

interface mide_rsp_if;
   logic       valid;
   logic       ready;
   logic       byte_valid;
   logic [7:0] id_byte;
   logic       id_last;
   logic       header_done;

   modport source (output valid, output byte_valid, output id_byte, output id_last,
                   output header_done, input ready);
   modport sink   (input valid, input byte_valid, input id_byte, input id_last,
                   input header_done, output ready);
endinterface

`default_nettype wire

@@ src/message_id_list_extractor.sv @@
// message_id_list_extractor: parses header bytes and emits message-id bytes
// depends on mide_pkg, mide_req_if and mide_rsp_if
//
// usage:
//   req carries one header byte per beat, with end_of_header on the final byte.
//   rsp carries the results: id bytes with id_last on the final byte of each id,
//   and header_done on the last result belonging to the final header byte.
//   a header byte causes zero, one or two results; the final byte always
//   causes at least one (byte_valid low if no id byte is left).
//   results are registered into the output queue and offered on rsp from there.
//   throughput: one header byte per cycle; the parse state is updated in the
//   same cycle the byte is taken, and results go to a four-entry output queue.
//   req.ready is high while the queue holds at most two results, so a stream
//   giving one result per byte or fewer runs at full rate; bytes giving two
//   results are limited by the single-result rsp port.
//   when rsp stalls, the queue fills and req.ready drops until it drains.
//   reset (synchronous) empties the queue and returns to the leading skip phase;
//   req.ready is low while reset is high.
`default_nettype none

module message_id_list_extractor
   import mide_pkg::*;
(
   input  wire       clock,
   input  wire       reset,
   mide_req_if.sink   req,
   mide_rsp_if.source rsp
);

   phase_type             phase_ff,  phase_in;
   logic [DepthWidth-1:0] depth_ff,  depth_in;
   logic                  esc_ff,    esc_in;
   logic [7:0]            held_ff,   held_in;
   logic                  hvalid_ff, hvalid_in;

   result_type            queue_ff [QueueDepth];
   logic [QueuePtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]  cnt_ff,    cnt_in;

   result_type            res [2];
   logic [1:0]            n_res;
   logic                  accept, pop;
   logic [7:0]            b;
   logic [DepthWidth-1:0] depth_dec;
   logic [QueuePtrW-1:0]  wr_ptr0, wr_ptr1;

   assign b = req.in_byte;

   // parse one byte
   always_comb begin
      phase_in  = phase_ff;
      depth_in  = depth_ff;
      esc_in    = esc_ff;
      held_in   = held_ff;
      hvalid_in = hvalid_ff;
      n_res     = 2'd0;
      res[0]    = '0;
      res[1]    = '0;
      depth_dec = (depth_ff != '0) ? depth_ff - DepthWidth'(1) : '0;

      case (phase_ff)
         PH_LEAD, PH_POST: begin
            if (is_ws(b)) begin
               phase_in = phase_ff;
            end else if (b == CharLparen) begin
               depth_in = DepthWidth'(1);
               esc_in   = 1'b0;
               phase_in = (phase_ff == PH_LEAD) ? PH_LEAD_CMT : PH_POST_CMT;
            end else if (phase_ff == PH_LEAD) begin
               phase_in = (b == CharLt) ? PH_POST : PH_TEXT;
            end else if (b == CharGt) begin
               phase_in = PH_LEAD;
            end else begin
               held_in   = b;
               hvalid_in = 1'b1;
               phase_in  = PH_ID;
            end
         end
         PH_LEAD_CMT, PH_POST_CMT: begin
            if (esc_ff) begin
               esc_in = 1'b0;
            end else if (b == CharBackslash) begin
               esc_in = 1'b1;
            end else if (b == CharLparen) begin
               if (depth_ff < MaxCommentDepth) depth_in = depth_ff + DepthWidth'(1);
            end else if (b == CharRparen) begin
               depth_in = depth_dec;
               if (depth_dec == '0)
                  phase_in = (phase_ff == PH_LEAD_CMT) ? PH_LEAD : PH_POST;
            end
         end
         PH_TEXT: begin
            if (b == CharLt) phase_in = PH_POST;
         end
         PH_ID: begin
            if (b == CharGt) begin
               if (hvalid_ff) begin
                  res[0] = '{byte_valid: 1'b1, id_byte: held_ff, id_last: 1'b1,
                             header_done: 1'b0};
                  n_res  = 2'd1;
               end
               hvalid_in = 1'b0;
               held_in   = '0;
               phase_in  = PH_LEAD;
            end else if ((b == CharSpace) || (b == CharTab)) begin
               phase_in = PH_ID;
            end else begin
               if (hvalid_ff) begin
                  res[0] = '{byte_valid: 1'b1, id_byte: held_ff, id_last: 1'b0,
                             header_done: 1'b0};
                  n_res  = 2'd1;
               end
               held_in   = b;
               hvalid_in = 1'b1;
            end
         end
         default: begin
            phase_in = PH_LEAD;
         end
      endcase

      if (req.end_of_header) begin
         if (hvalid_in) begin
            res[n_res[0]] = '{byte_valid: 1'b1, id_byte: held_in, id_last: 1'b1,
                              header_done: 1'b0};
            n_res = n_res + 2'd1;
         end
         if (n_res == 2'd0) begin
            res[0] = '0;
            n_res  = 2'd1;
         end
         if (n_res == 2'd1) res[0].header_done = 1'b1;
         else               res[1].header_done = 1'b1;
         phase_in  = PH_LEAD;
         depth_in  = '0;
         esc_in    = 1'b0;
         held_in   = '0;
         hvalid_in = 1'b0;
      end
   end

   // output queue
   assign req.ready = !reset && (cnt_ff <= QueueCntW'(QueueDepth - 2));
   assign accept    = req.valid && req.ready;
   assign pop       = rsp.valid && rsp.ready;
   assign wr_ptr0   = rd_ptr_ff + cnt_ff[QueuePtrW-1:0];
   assign wr_ptr1   = wr_ptr0 + QueuePtrW'(1);

   always_comb begin
      rd_ptr_in = pop ? rd_ptr_ff + QueuePtrW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + (accept ? QueueCntW'(n_res) : '0) - (pop ? QueueCntW'(1) : '0);
   end

   assign rsp.valid       = (cnt_ff != '0);
   assign rsp.byte_valid  = queue_ff[rd_ptr_ff].byte_valid;
   assign rsp.id_byte     = queue_ff[rd_ptr_ff].id_byte;
   assign rsp.id_last     = queue_ff[rd_ptr_ff].id_last;
   assign rsp.header_done = queue_ff[rd_ptr_ff].header_done;

   always_ff @(posedge clock) begin
      if (accept) begin
         if (n_res != 2'd0) queue_ff[wr_ptr0] <= res[0];
         if (n_res == 2'd2) queue_ff[wr_ptr1] <= res[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LEAD;
         depth_ff  <= '0;
         esc_ff    <= 1'b0;
         held_ff   <= '0;
         hvalid_ff <= 1'b0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            depth_ff  <= depth_in;
            esc_ff    <= esc_in;
            held_ff   <= held_in;
            hvalid_ff <= hvalid_in;
         end
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire
